>>> sv/acmc_pkg.sv
package acmc_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned TIME_W = 6;
  localparam int unsigned TCOL_W = 2;

  // Event codes carried by the operation field.
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_B1_SHORT = 3'd1;
  localparam logic [OP_W-1:0] OP_B1_LONG  = 3'd2;
  localparam logic [OP_W-1:0] OP_B2_SHORT = 3'd3;
  localparam logic [OP_W-1:0] OP_B2_LONG  = 3'd4;
  localparam logic [OP_W-1:0] OP_B3_SHORT = 3'd5;
  localparam logic [OP_W-1:0] OP_B3_LONG  = 3'd6;

  // Time display colors.
  localparam logic [TCOL_W-1:0] TCOL_NORMAL = 2'd0;
  localparam logic [TCOL_W-1:0] TCOL_BLANK  = 2'd1;
  localparam logic [TCOL_W-1:0] TCOL_ALARM  = 2'd2;

  localparam logic [TIME_W-1:0] SEC_MAX        = 6'd59;
  localparam logic [TIME_W-1:0] MAX_MINUTE_RST = 6'd2;

  // Step up with wrap: anything at or above the top goes to zero.
  function automatic logic [TIME_W-1:0] wrap_inc(input logic [TIME_W-1:0] v,
                                                 input logic [TIME_W-1:0] top);
    wrap_inc = (v >= top) ? '0 : v + TIME_W'(1);
  endfunction

  // Step down with wrap: zero or an out-of-range value goes to the top.
  function automatic logic [TIME_W-1:0] wrap_dec(input logic [TIME_W-1:0] v,
                                                 input logic [TIME_W-1:0] top);
    wrap_dec = (v == '0 || v > top) ? top : v - TIME_W'(1);
  endfunction

endpackage

>>> sv/alarm_clock_mode_controller.sv
// Alarm clock mode controller. Each input beat is one event (a one-second
// tick or a short or long press of one of three buttons) together with the
// current blink phase, and each input beat yields exactly one output beat
// that shows the clock state after the event: mode, clock time, displayed
// alarm time, display colors, bell and buzzer flags and the edit selection.
// An event is applied in the cycle it is accepted and its output beat is
// valid on the next cycle, so the block sustains one beat per clock; the
// only thing that holds off input is a stalled output beat, because the
// single output register is the one place a finished beat can wait. The
// minute wrap point is set by the max_minute register (reset value 2),
// written through cfg_we and cfg_wdata; write it only while no beat is in
// flight.
module alarm_clock_mode_controller (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write port for max_minute.
  input  logic                         cfg_we,
  input  logic [acmc_pkg::TIME_W-1:0]  cfg_wdata,
  // Event channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [acmc_pkg::OP_W-1:0]    operation,
  input  logic                         blink_phase,
  // Display channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [acmc_pkg::MODE_W-1:0]  mode,
  output logic [acmc_pkg::TIME_W-1:0]  minutes,
  output logic [acmc_pkg::TIME_W-1:0]  seconds,
  output logic [acmc_pkg::TIME_W-1:0]  alarm_minutes_shown,
  output logic [acmc_pkg::TIME_W-1:0]  alarm_seconds_shown,
  output logic [acmc_pkg::TCOL_W-1:0]  time_color,
  output logic                         alarm_color,
  output logic                         bell_on,
  output logic                         buzzer_on,
  output logic                         editing_seconds
);
  import acmc_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_TIME  = 2'd0,
    MODE_RUN       = 2'd1,
    MODE_SET_ALARM = 2'd2
  } mode_t;

  // Architectural state.
  logic [TIME_W-1:0] max_minute;
  mode_t             mode_reg;
  logic [TIME_W-1:0] clock_minutes;
  logic [TIME_W-1:0] clock_seconds;
  logic [TIME_W-1:0] alarm_minutes;
  logic [TIME_W-1:0] alarm_seconds;
  logic              armed;
  logic              ringing;
  logic              time_edit_seconds;
  logic              alarm_edit_seconds;

  mode_t             mode_reg_next;
  logic [TIME_W-1:0] clock_minutes_next;
  logic [TIME_W-1:0] clock_seconds_next;
  logic [TIME_W-1:0] alarm_minutes_next;
  logic [TIME_W-1:0] alarm_seconds_next;
  logic              armed_next;
  logic              ringing_next;
  logic              time_edit_seconds_next;
  logic              alarm_edit_seconds_next;

  // Display fields drawn from the next state.
  logic [TIME_W-1:0] shown_am_next;
  logic [TIME_W-1:0] shown_as_next;
  logic [TCOL_W-1:0] tcol_next;
  logic              acol_next;
  logic              edit_next;

  // Clock advanced by one second, used by both counting modes.
  logic [TIME_W-1:0] tick_minutes;
  logic [TIME_W-1:0] tick_seconds;

  logic in_accept;
  logic press_up;
  logic press_down;

  // A beat may enter whenever the output register is free or being drained.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign press_up   = (operation == OP_B1_SHORT) || (operation == OP_B1_LONG);
  assign press_down = (operation == OP_B2_SHORT) || (operation == OP_B2_LONG);

  always_comb begin
    if (clock_seconds >= SEC_MAX) begin
      tick_seconds = '0;
      tick_minutes = wrap_inc(clock_minutes, max_minute);
    end else begin
      tick_seconds = clock_seconds + TIME_W'(1);
      tick_minutes = clock_minutes;
    end
  end

  always_comb begin
    mode_reg_next           = mode_reg;
    clock_minutes_next      = clock_minutes;
    clock_seconds_next      = clock_seconds;
    alarm_minutes_next      = alarm_minutes;
    alarm_seconds_next      = alarm_seconds;
    armed_next              = armed;
    ringing_next            = ringing;
    time_edit_seconds_next  = time_edit_seconds;
    alarm_edit_seconds_next = alarm_edit_seconds;

    case (mode_reg)
      MODE_RUN: begin
        if (operation == OP_TICK) begin
          clock_minutes_next = tick_minutes;
          clock_seconds_next = tick_seconds;
        end
        if (operation == OP_B1_LONG) begin
          armed_next   = 1'b0;
          ringing_next = 1'b0;
        end else if (operation == OP_B3_LONG) begin
          mode_reg_next = MODE_SET_ALARM;
        end else if (operation == OP_B3_SHORT) begin
          armed_next = ~armed;
        end
        // The ring check runs only when the clock stays in run mode.
        if (operation != OP_B3_LONG) begin
          if (!armed_next) begin
            ringing_next = 1'b0;
          end else if (clock_minutes_next == alarm_minutes &&
                       clock_seconds_next == alarm_seconds) begin
            ringing_next = 1'b1;
          end
        end
      end
      MODE_SET_ALARM: begin
        if (operation == OP_TICK) begin
          clock_minutes_next = tick_minutes;
          clock_seconds_next = tick_seconds;
        end else if (operation == OP_B3_SHORT) begin
          alarm_edit_seconds_next = ~alarm_edit_seconds;
        end else if (operation == OP_B3_LONG) begin
          mode_reg_next = MODE_RUN;
        end else if (press_up) begin
          if (alarm_edit_seconds) begin
            alarm_seconds_next = wrap_inc(alarm_seconds, SEC_MAX);
          end else begin
            alarm_minutes_next = wrap_inc(alarm_minutes, max_minute);
          end
        end else if (press_down) begin
          if (alarm_edit_seconds) begin
            alarm_seconds_next = wrap_dec(alarm_seconds, SEC_MAX);
          end else begin
            alarm_minutes_next = wrap_dec(alarm_minutes, max_minute);
          end
        end
      end
      MODE_SET_TIME: begin
        // Ticks are ignored while the time is being set.
        if (operation == OP_B3_SHORT) begin
          time_edit_seconds_next = ~time_edit_seconds;
        end else if (operation == OP_B3_LONG) begin
          mode_reg_next = MODE_RUN;
        end else if (press_up) begin
          if (time_edit_seconds) begin
            clock_seconds_next = wrap_inc(clock_seconds, SEC_MAX);
          end else begin
            clock_minutes_next = wrap_inc(clock_minutes, max_minute);
          end
        end else if (press_down) begin
          if (time_edit_seconds) begin
            clock_seconds_next = wrap_dec(clock_seconds, SEC_MAX);
          end else begin
            clock_minutes_next = wrap_dec(clock_minutes, max_minute);
          end
        end
      end
      default: begin
        // An undefined mode drops the event and falls back to setting time.
        mode_reg_next = MODE_SET_TIME;
      end
    endcase
  end

  // The display is drawn from the mode after the event.
  always_comb begin
    shown_am_next = '0;
    shown_as_next = '0;
    tcol_next     = TCOL_NORMAL;
    acol_next     = 1'b0;
    edit_next     = 1'b0;
    case (mode_reg_next)
      MODE_SET_TIME: begin
        tcol_next = blink_phase ? TCOL_BLANK : TCOL_NORMAL;
        edit_next = time_edit_seconds_next;
      end
      MODE_RUN: begin
        shown_am_next = alarm_minutes_next;
        shown_as_next = alarm_seconds_next;
        tcol_next     = ringing_next ? TCOL_ALARM : TCOL_NORMAL;
      end
      default: begin
        shown_am_next = alarm_minutes_next;
        shown_as_next = alarm_seconds_next;
        acol_next     = blink_phase;
        edit_next     = alarm_edit_seconds_next;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_minute         <= MAX_MINUTE_RST;
      mode_reg           <= MODE_SET_TIME;
      clock_minutes      <= '0;
      clock_seconds      <= '0;
      alarm_minutes      <= '0;
      alarm_seconds      <= '0;
      armed              <= 1'b0;
      ringing            <= 1'b0;
      time_edit_seconds  <= 1'b0;
      alarm_edit_seconds <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_minute <= cfg_wdata;
      end
      if (in_accept) begin
        mode_reg           <= mode_reg_next;
        clock_minutes      <= clock_minutes_next;
        clock_seconds      <= clock_seconds_next;
        alarm_minutes      <= alarm_minutes_next;
        alarm_seconds      <= alarm_seconds_next;
        armed              <= armed_next;
        ringing            <= ringing_next;
        time_edit_seconds  <= time_edit_seconds_next;
        alarm_edit_seconds <= alarm_edit_seconds_next;
      end
    end
  end

  // Output register: valid is control, the payload loads on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode                <= mode_reg_next;
      minutes             <= clock_minutes_next;
      seconds             <= clock_seconds_next;
      alarm_minutes_shown <= shown_am_next;
      alarm_seconds_shown <= shown_as_next;
      time_color          <= tcol_next;
      alarm_color         <= acol_next;
      bell_on             <= armed_next;
      buzzer_on           <= ringing_next;
      editing_seconds     <= edit_next;
    end
  end

endmodule
